// File: src/plr_pkg.sv
// Shared types, constants and the log2 table for the price log-return block.
package plr_pkg;

    // Fixed-point format of the result and size of the log2 table
    localparam int FRAC_BITS      = 24;
    localparam int LOG_TABLE_BITS = 8;
    localparam int INTERP_BITS    = 32 - LOG_TABLE_BITS;
    localparam int ROM_SIZE       = (1 << LOG_TABLE_BITS) + 1;
    localparam int ROM_IDX_BITS   = LOG_TABLE_BITS + 1;

    // Datapath widths
    localparam int PRICE_BITS = 63;   // positive price magnitude
    localparam int EXP_BITS   = 6;    // msb position 0..62
    localparam int LOG_BITS   = 38;   // log2 in Q6.32
    localparam int MAG_BITS   = 32;   // log difference in Q.26

    // ln(2) in Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Command queue between front and back
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_COMPUTED = 2'd0,
        ST_NO_BID   = 2'd1,
        ST_NON_POS  = 2'd2,
        ST_FIRST    = 2'd3
    } status_t;

    // One classified update handed from front to back
    typedef struct packed {
        status_t                 status;
        logic [PRICE_BITS-1:0]   cur;
        logic [PRICE_BITS-1:0]   prev;
    } cmd_t;

    typedef logic [32:0] rom_word_t;
    typedef rom_word_t rom_t [ROM_SIZE];

    // log2(v) for v in [1,2] given in Q1.31, result Q0.32, by repeated squaring
    function automatic rom_word_t log2_q31(logic [63:0] v_in);
        logic [63:0] v;
        rom_word_t   y;
        v = v_in;
        y = '0;
        if (v >= 64'h1_0000_0000) begin
            return 33'h1_0000_0000;
        end
        for (int k = 1; k <= 32; k++) begin
            v = (v * v) >> 31;
            if (v >= 64'h1_0000_0000) begin
                v = v >> 1;
                y[32-k] = 1'b1;
            end
        end
        return y;
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < ROM_SIZE; i++) begin
            r[i] = log2_q31((64'd1 << 31) + (64'(i) << (31 - LOG_TABLE_BITS)));
        end
        return r;
    endfunction

    // Table of log2(1 + i / 2^LOG_TABLE_BITS), Q0.32, built at elaboration
    localparam rom_t LOG_ROM = build_rom();

endpackage

// File: src/plr_front.sv
// Front end: accepts bid updates, classifies them and tracks the stored price.
module plr_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            in_present,
    input  logic [63:0]     in_price,
    input  logic            queue_full,
    output logic            in_ready,
    output logic            push_valid,
    output plr_pkg::cmd_t   push_cmd
);

    logic                            have_prev_reg;
    logic [plr_pkg::PRICE_BITS-1:0]  prev_price_reg;
    logic                            accept;
    logic                            price_ok;

    assign in_ready   = !queue_full;
    assign accept     = in_valid && !queue_full;
    assign push_valid = accept;
    assign price_ok   = !in_price[63] && (in_price != 64'd0);

    // Classify the transaction
    always_comb begin
        push_cmd.cur  = in_price[plr_pkg::PRICE_BITS-1:0];
        push_cmd.prev = prev_price_reg;
        if (!in_present) begin
            push_cmd.status = plr_pkg::ST_NO_BID;
        end else if (!price_ok) begin
            push_cmd.status = plr_pkg::ST_NON_POS;
        end else if (!have_prev_reg) begin
            push_cmd.status = plr_pkg::ST_FIRST;
        end else begin
            push_cmd.status = plr_pkg::ST_COMPUTED;
        end
    end

    // Stored price follows every accepted positive bid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg  <= 1'b0;
            prev_price_reg <= '0;
        end else if (accept && in_present && price_ok) begin
            have_prev_reg  <= 1'b1;
            prev_price_reg <= in_price[plr_pkg::PRICE_BITS-1:0];
        end
    end

endmodule

// File: src/plr_queue.sv
// Short command queue decoupling the front end from the back end.
module plr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  plr_pkg::cmd_t   push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output plr_pkg::cmd_t   head_cmd
);

    plr_pkg::cmd_t                        entry_reg [plr_pkg::QUEUE_DEPTH];
    logic [plr_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_reg;
    logic [plr_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_reg;
    logic [plr_pkg::QUEUE_CNT_BITS-1:0]   count_reg;
    logic                                 do_push;
    logic                                 do_pop;

    assign full       = (count_reg == plr_pkg::QUEUE_CNT_BITS'(plr_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [plr_pkg::QUEUE_PTR_BITS-1:0] ptr_inc(
        logic [plr_pkg::QUEUE_PTR_BITS-1:0] p);
        if (p == plr_pkg::QUEUE_PTR_BITS'(plr_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/plr_log2.sv
// Five-stage pipelined log2 of a positive 63-bit value, result in Q6.32.
module plr_log2 (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  logic [plr_pkg::PRICE_BITS-1:0]    in_x,
    output logic                              out_valid,
    output logic [plr_pkg::LOG_BITS-1:0]      out_log
);

    localparam int IB = plr_pkg::INTERP_BITS;
    localparam int TB = plr_pkg::LOG_TABLE_BITS;

    logic [4:0]                          valid_reg;

    // Stage 1: msb position
    logic [plr_pkg::PRICE_BITS-1:0]      x1_reg;
    logic [plr_pkg::EXP_BITS-1:0]        e1_reg;
    logic [plr_pkg::EXP_BITS-1:0]        msb;

    // Stage 2: normalize, split fraction into table index and remainder
    logic [plr_pkg::EXP_BITS-1:0]        e2_reg;
    logic [TB-1:0]                       idx2_reg;
    logic [IB-1:0]                       r2_reg;
    logic [plr_pkg::PRICE_BITS-1:0]      norm;
    logic [31:0]                         frac;

    // Stage 3: table lookup
    logic [plr_pkg::EXP_BITS-1:0]        e3_reg;
    logic [32:0]                         lo3_reg;
    logic [32:0]                         diff3_reg;
    logic [IB-1:0]                       r3_reg;
    logic [plr_pkg::ROM_IDX_BITS-1:0]    idx_lo;
    logic [plr_pkg::ROM_IDX_BITS-1:0]    idx_hi;
    logic [32:0]                         rom_lo;
    logic [32:0]                         rom_hi;

    // Stage 4: interpolation product
    logic [plr_pkg::EXP_BITS-1:0]        e4_reg;
    logic [32:0]                         lo4_reg;
    logic [32:0]                         interp4_reg;
    logic [33+IB-1:0]                    interp_prod;

    // Stage 5: assemble
    logic [plr_pkg::LOG_BITS-1:0]        log5_reg;

    always_comb begin
        msb = '0;
        for (int i = 0; i < plr_pkg::PRICE_BITS; i++) begin
            if (in_x[i]) begin
                msb = plr_pkg::EXP_BITS'(i);
            end
        end
    end

    assign norm   = x1_reg << (plr_pkg::EXP_BITS'(plr_pkg::PRICE_BITS - 1) - e1_reg);
    assign frac   = norm[61:30];
    assign idx_lo = {1'b0, idx2_reg};
    assign idx_hi = idx_lo + 1'b1;
    assign rom_lo = plr_pkg::LOG_ROM[idx_lo];
    assign rom_hi = plr_pkg::LOG_ROM[idx_hi];
    assign interp_prod = diff3_reg * {{33{1'b0}}, r3_reg};

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        x1_reg      <= in_x;
        e1_reg      <= msb;
        e2_reg      <= e1_reg;
        idx2_reg    <= frac[31 -: TB];
        r2_reg      <= frac[IB-1:0];
        e3_reg      <= e2_reg;
        lo3_reg     <= rom_lo;
        diff3_reg   <= rom_hi - rom_lo;
        r3_reg      <= r2_reg;
        e4_reg      <= e3_reg;
        lo4_reg     <= lo3_reg;
        interp4_reg <= interp_prod[IB +: 33];
        log5_reg    <= {e4_reg, 32'd0} + {5'd0, lo4_reg} + {5'd0, interp4_reg};
    end

    assign out_valid = valid_reg[4];
    assign out_log   = log5_reg;

endmodule

// File: src/plr_back.sv
// Back end: runs the log difference for computed updates and holds the result.
module plr_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              head_valid,
    input  plr_pkg::cmd_t                     head_cmd,
    output logic                              pop,
    output logic                              log_in_valid,
    output logic [plr_pkg::PRICE_BITS-1:0]    log_in_x,
    input  logic                              log_out_valid,
    input  logic [plr_pkg::LOG_BITS-1:0]      log_out,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [31:0]                       out_return,
    output plr_pkg::status_t                  out_status
);

    localparam int RND_SHIFT = 58 - plr_pkg::FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED_PREV,
        S_WAIT_CUR,
        S_WAIT_PREV,
        S_MUL,
        S_FINAL
    } state_t;

    state_t                               state_reg;
    logic [plr_pkg::PRICE_BITS-1:0]       prev_reg;
    logic [plr_pkg::LOG_BITS-1:0]         lc_reg;
    logic                                 neg_reg;
    logic [plr_pkg::MAG_BITS-1:0]         mag_reg;
    logic [63:0]                          prod_reg;
    logic                                 out_valid_reg;
    logic [31:0]                          out_return_reg;
    plr_pkg::status_t                     out_status_reg;

    logic                                 out_free;
    logic                                 out_load;
    logic                                 neg;
    logic [plr_pkg::LOG_BITS-1:0]         diff;
    logic [plr_pkg::LOG_BITS:0]           diff_rnd;
    logic [64:0]                          prod_rnd;
    logic [64:0]                          res;
    logic [31:0]                          res_sat;
    logic [31:0]                          ret;

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == S_IDLE) && head_valid && out_free;

    // A new result enters the output register this cycle
    assign out_load = (pop && (head_cmd.status != plr_pkg::ST_COMPUTED))
                      || ((state_reg == S_FINAL) && out_free);

    // Feed current price, then previous price, into the log unit
    assign log_in_valid = (pop && (head_cmd.status == plr_pkg::ST_COMPUTED))
                          || (state_reg == S_FEED_PREV);
    assign log_in_x     = (state_reg == S_FEED_PREV) ? prev_reg : head_cmd.cur;

    // Log difference as sign and magnitude, rounded to Q.26
    assign neg      = lc_reg < log_out;
    assign diff     = neg ? (log_out - lc_reg) : (lc_reg - log_out);
    assign diff_rnd = {1'b0, diff} + (plr_pkg::LOG_BITS+1)'(32);

    // Round the Q.58 product to the output format and saturate
    assign prod_rnd = {1'b0, prod_reg} + (65'd1 << (RND_SHIFT - 1));
    assign res      = prod_rnd >> RND_SHIFT;
    always_comb begin
        if (neg_reg) begin
            res_sat = (res > 65'h8000_0000) ? 32'h8000_0000 : res[31:0];
            ret     = 32'd0 - res_sat;
        end else begin
            res_sat = (res > 65'h7FFF_FFFF) ? 32'h7FFF_FFFF : res[31:0];
            ret     = res_sat;
        end
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (pop) begin
                        prev_reg <= head_cmd.prev;
                        if (head_cmd.status == plr_pkg::ST_COMPUTED) begin
                            state_reg <= S_FEED_PREV;
                        end else begin
                            out_valid_reg  <= 1'b1;
                            out_return_reg <= 32'd0;
                            out_status_reg <= head_cmd.status;
                        end
                    end
                end
                S_FEED_PREV: begin
                    state_reg <= S_WAIT_CUR;
                end
                S_WAIT_CUR: begin
                    if (log_out_valid) begin
                        lc_reg    <= log_out;
                        state_reg <= S_WAIT_PREV;
                    end
                end
                S_WAIT_PREV: begin
                    neg_reg   <= neg;
                    mag_reg   <= diff_rnd[6 +: plr_pkg::MAG_BITS];
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= {32'd0, mag_reg} * {32'd0, plr_pkg::LN2_Q32};
                    state_reg <= S_FINAL;
                end
                S_FINAL: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_return_reg <= ret;
                        out_status_reg <= plr_pkg::ST_COMPUTED;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_return = out_return_reg;
    assign out_status = out_status_reg;

`ifndef SYNTH
    // Only a computed result carries a nonzero return
    a_zero_unless_computed: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && (out_status != plr_pkg::ST_COMPUTED) |-> out_return == 32'd0)
        else $error("nonzero return on a status-only result");

    // Previous-price log follows the current-price log in the next cycle
    a_prev_log_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WAIT_PREV |-> log_out_valid)
        else $error("previous-price log missing");

    // The log unit is fed only when issuing operands
    a_feed_states: assert property (@(posedge aclk) disable iff (!aresetn)
        log_in_valid |-> (state_reg == S_IDLE || state_reg == S_FEED_PREV))
        else $error("log unit fed outside issue states");

    // A pop happens only when the output slot can take a result
    a_pop_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid && (!out_valid || out_ready))
        else $error("pop without room for the result");
`endif

endmodule

// File: src/price_log_return.sv
// Top level of the best-bid price log-return block.
//
// Input channel (s_): one transaction per best-bid update, s_tdata the signed
// raw price, s_tuser the presence flag. Output channel (m_): one transaction
// per update, m_tdata the log return in signed Q7.24, m_tuser the status
// (computed, no bid, non-positive bid, first price stored).
// The front end classifies each update and keeps the last positive price; a
// two-entry command queue hands the work to the back end.
// The back end takes one update at a time. A computed return feeds the
// five-stage log2 pipeline twice, current price then previous price, followed
// by the difference, ln2 multiply and rounding steps; a status-only result
// goes straight from the queue head into the output register.
// Reset (aresetn low, synchronous) clears the stored price, empties the queue
// and drops any pending result. When the receiver stalls, the result waits
// in the output register while the queue keeps taking updates until full.
module price_log_return (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,    // [63:0] bid_price
    input  logic         s_tuser,    // [0] bid_present
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,    // [31:0] ln_ret
    output logic [1:0]   m_tuser     // [1:0] status
);

    logic                               push_valid;
    plr_pkg::cmd_t                      push_cmd;
    logic                               queue_full;
    logic                               pop;
    logic                               head_valid;
    plr_pkg::cmd_t                      head_cmd;
    logic                               log_in_valid;
    logic [plr_pkg::PRICE_BITS-1:0]     log_in_x;
    logic                               log_out_valid;
    logic [plr_pkg::LOG_BITS-1:0]       log_out;
    plr_pkg::status_t                   out_status;

    plr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_present (s_tuser),
        .in_price   (s_tdata),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    plr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    plr_log2 u_log2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (log_in_valid),
        .in_x      (log_in_x),
        .out_valid (log_out_valid),
        .out_log   (log_out)
    );

    plr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .log_in_valid  (log_in_valid),
        .log_in_x      (log_in_x),
        .log_out_valid (log_out_valid),
        .log_out       (log_out),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_return    (m_tdata),
        .out_status    (out_status)
    );

    assign m_tuser = 2'(out_status);

endmodule
